FILE: src/lfd_pkg.sv
`timescale 1ns / 1ps
package lfd_pkg;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_TOTAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COUNT = 1'b1;
   localparam logic [15:0] LED_TOTAL_RST = 16'd1024;
   localparam logic [15:0] MAX_COUNT_RST = 16'd5000;

   // result kinds
   localparam logic [1:0] RK_PIXEL = 2'd0;
   localparam logic [1:0] RK_MARKER = 2'd1;
   localparam logic [1:0] RK_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] EC_MAGIC = 3'd0;
   localparam logic [2:0] EC_VERSION = 3'd1;
   localparam logic [2:0] EC_COUNT = 3'd2;
   localparam logic [2:0] EC_FORMAT = 3'd3;
   localparam logic [2:0] EC_CLOSED = 3'd4;
   localparam logic [2:0] EC_NONE = 3'd0;

   // pixel formats
   localparam logic [2:0] FMT_RGB = 3'd0;
   localparam logic [2:0] FMT_GRB = 3'd1;
   localparam logic [2:0] FMT_BGR = 3'd2;
   localparam logic [2:0] FMT_RGBW = 3'd3;
   localparam logic [2:0] FMT_GRBW = 3'd4;

   localparam logic [7:0] HDR_VERSION = 8'h01;
   localparam logic [3:0] HDR_POS_VERSION = 4'd4;
   localparam logic [3:0] HDR_POS_COUNT_LAST = 4'd8;
   localparam logic [3:0] HDR_POS_FORMAT = 4'd9;

   // floor(s / 3) for s <= 765 as (s * 683) >> 11
   localparam logic [9:0] DIV3_MUL = 10'd683;
   localparam int DIV3_SHIFT = 11;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW = $clog2(Q_DEPTH);

   typedef struct packed {
      logic [1:0]  rkind;
      logic [15:0] idx;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic [2:0]  fmt;
      logic        last;
      logic [2:0]  ecode;
   } job_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] pos);
      logic [7:0] m;
      case (pos)
         2'd0: m = 8'h4C;
         2'd1: m = 8'h45;
         2'd2: m = 8'h44;
         default: m = 8'h53;
      endcase
      return m;
   endfunction

endpackage

FILE: src/lfd_if.sv
`timescale 1ns / 1ps
interface lfd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, kind, data_byte, input ready);
   modport sink (input valid, kind, data_byte, output ready);
endinterface

interface lfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] pixel_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  white;
   logic        frame_end;
   logic [2:0]  error_code;

   modport source (output valid, result_kind, pixel_index, red, green, blue, white,
                   frame_end, error_code, input ready);
   modport sink (input valid, result_kind, pixel_index, red, green, blue, white,
                 frame_end, error_code, output ready);
endinterface

FILE: src/lfd_front.sv
`timescale 1ns / 1ps
module lfd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [7:0]                     req_data_byte,
   input  logic                           csr_we,
   input  logic [lfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           q_full,
   output logic                           q_push,
   output lfd_pkg::job_type               q_job
);
   import lfd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_DROP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hpos_ff, hpos_in;
   logic [31:0] count_ff, count_in;
   logic [2:0]  fmt_ff, fmt_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] cur_ff, cur_in;
   logic [1:0]  bip_ff, bip_in;
   logic [23:0] held_ff, held_in;
   logic [15:0] led_total_ff;
   logic [15:0] max_count_ff;

   logic        fire;
   logic [7:0]  b;
   logic [31:0] count_shift;
   logic        four;
   logic [1:0]  last_byte;
   logic [16:0] idx_plus;
   logic        is_last;
   job_type     job;
   logic        emit;

   assign req_ready = !q_full;
   assign fire = req_valid && req_ready;
   assign b = req_data_byte;
   assign count_shift = {count_ff[23:0], b};
   assign four = (fmt_ff == FMT_RGBW) || (fmt_ff == FMT_GRBW);
   assign last_byte = four ? 2'd3 : 2'd2;
   assign idx_plus = {1'b0, cur_ff} + 17'd1;
   assign is_last = idx_plus >= {1'b0, total_ff};

   always_comb begin
      phase_in = phase_ff;
      hpos_in = hpos_ff;
      count_in = count_ff;
      fmt_in = fmt_ff;
      total_in = total_ff;
      cur_in = cur_ff;
      bip_in = bip_ff;
      held_in = held_ff;
      emit = 1'b0;
      job = '0;
      job.fmt = fmt_ff;
      job.b0 = held_ff[7:0];
      job.b1 = held_ff[15:8];
      job.b2 = four ? held_ff[23:16] : b;
      job.b3 = b;
      job.idx = cur_ff;
      if (req_kind) begin
         if (phase_ff == PH_PAYLOAD || (phase_ff == PH_HEADER && hpos_ff != 4'd0)) begin
            emit = 1'b1;
            job.rkind = RK_ERROR;
            job.ecode = EC_CLOSED;
            job.idx = '0;
         end
         phase_in = PH_HEADER;
         hpos_in = 4'd0;
         count_in = '0;
         bip_in = 2'd0;
         cur_in = '0;
      end else if (phase_ff == PH_HEADER) begin
         hpos_in = hpos_ff + 4'd1;
         if (hpos_ff < HDR_POS_VERSION) begin
            if (b != magic_byte(hpos_ff[1:0])) begin
               emit = 1'b1;
               job.ecode = EC_MAGIC;
            end
         end else if (hpos_ff == HDR_POS_VERSION) begin
            if (b != HDR_VERSION) begin
               emit = 1'b1;
               job.ecode = EC_VERSION;
            end
         end else if (hpos_ff <= HDR_POS_COUNT_LAST) begin
            count_in = count_shift;
            if (hpos_ff == HDR_POS_COUNT_LAST) begin
               if (count_shift == 32'd0 || count_shift > {16'd0, max_count_ff}) begin
                  emit = 1'b1;
                  job.ecode = EC_COUNT;
               end else begin
                  total_in = count_shift[15:0];
               end
            end
         end else begin
            if (b > {5'd0, FMT_GRBW}) begin
               emit = 1'b1;
               job.ecode = EC_FORMAT;
            end else begin
               fmt_in = b[2:0];
               phase_in = PH_PAYLOAD;
               cur_in = '0;
               bip_in = 2'd0;
               hpos_in = 4'd0;
            end
         end
         if (emit) begin
            // header error: position holds, drop until close
            job.rkind = RK_ERROR;
            job.idx = '0;
            phase_in = PH_DROP;
            hpos_in = hpos_ff;
         end
      end else if (phase_ff == PH_PAYLOAD) begin
         if (bip_ff < last_byte) begin
            case (bip_ff)
               2'd0: held_in[7:0] = b;
               2'd1: held_in[15:8] = b;
               default: held_in[23:16] = b;
            endcase
            bip_in = bip_ff + 2'd1;
         end else begin
            bip_in = 2'd0;
            cur_in = idx_plus[15:0];
            if (is_last) begin
               phase_in = PH_HEADER;
               hpos_in = 4'd0;
               count_in = '0;
               bip_in = 2'd0;
               cur_in = '0;
            end
            job.last = is_last;
            if (cur_ff < led_total_ff) begin
               emit = 1'b1;
               job.rkind = RK_PIXEL;
            end else if (is_last) begin
               emit = 1'b1;
               job.rkind = RK_MARKER;
            end
         end
      end
   end

   assign q_push = fire && emit;
   assign q_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hpos_ff <= '0;
         count_ff <= '0;
         fmt_ff <= '0;
         total_ff <= '0;
         cur_ff <= '0;
         bip_ff <= '0;
         led_total_ff <= LED_TOTAL_RST;
         max_count_ff <= MAX_COUNT_RST;
      end else begin
         if (fire) begin
            phase_ff <= phase_in;
            hpos_ff <= hpos_in;
            count_ff <= count_in;
            fmt_ff <= fmt_in;
            total_ff <= total_in;
            cur_ff <= cur_in;
            bip_ff <= bip_in;
         end
         if (csr_we && csr_index == CSR_LED_TOTAL) begin
            led_total_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_MAX_COUNT) begin
            max_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         held_ff <= held_in;
      end
   end

endmodule

FILE: src/lfd_queue.sv
`timescale 1ns / 1ps
module lfd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lfd_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output lfd_pkg::job_type head_job
);
   import lfd_pkg::*;

   job_type         slot_ff [Q_DEPTH];
   logic [Q_AW-1:0] wptr_ff;
   logic [Q_AW-1:0] rptr_ff;
   logic [Q_AW:0]   cnt_ff;
   logic            do_pop;

   assign full = cnt_ff == (Q_AW+1)'(Q_DEPTH);
   assign empty = cnt_ff == '0;
   assign head_job = slot_ff[rptr_ff];
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (do_pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

FILE: src/lfd_back.sv
`timescale 1ns / 1ps
module lfd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  lfd_pkg::job_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [15:0]      rsp_pixel_index,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_white,
   output logic             rsp_frame_end,
   output logic [2:0]       rsp_error_code
);
   import lfd_pkg::*;

   logic        valid_ff;
   logic [1:0]  kind_ff;
   logic [15:0] idx_ff;
   logic [7:0]  red_ff, green_ff, blue_ff, white_ff;
   logic        end_ff;
   logic [2:0]  ecode_ff;

   logic [7:0]  r, g, bl, w;
   logic [9:0]  sum;
   logic [19:0] prod;
   logic        is_pixel;

   always_comb begin
      case (q_head.fmt)
         FMT_GRB, FMT_GRBW: begin
            g = q_head.b0;
            r = q_head.b1;
            bl = q_head.b2;
         end
         FMT_BGR: begin
            bl = q_head.b0;
            g = q_head.b1;
            r = q_head.b2;
         end
         default: begin
            r = q_head.b0;
            g = q_head.b1;
            bl = q_head.b2;
         end
      endcase
   end

   assign sum = {2'b0, r} + {2'b0, g} + {2'b0, bl};
   assign prod = {10'b0, sum} * {10'b0, DIV3_MUL};
   assign w = (q_head.fmt == FMT_RGBW || q_head.fmt == FMT_GRBW) ? q_head.b3
              : prod[DIV3_SHIFT +: 8];
   assign is_pixel = q_head.rkind == RK_PIXEL;

   // output register refills whenever it is empty or being drained
   assign q_pop = !q_empty && (!valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff <= q_head.rkind;
         idx_ff <= q_head.idx;
         red_ff <= is_pixel ? r : 8'd0;
         green_ff <= is_pixel ? g : 8'd0;
         blue_ff <= is_pixel ? bl : 8'd0;
         white_ff <= is_pixel ? w : 8'd0;
         end_ff <= q_head.last;
         ecode_ff <= q_head.ecode;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_pixel_index = idx_ff;
   assign rsp_red = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue = blue_ff;
   assign rsp_white = white_ff;
   assign rsp_frame_end = end_ff;
   assign rsp_error_code = ecode_ff;

endmodule

FILE: src/led_frame_deframer_pixel_unpack.sv
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// req_bus   in         valid / ready      kind, data_byte
// rsp_bus   out        valid / ready      result_kind, pixel_index, red, green, blue,
//                                         white, frame_end, error_code
// csr_*     in         csr_we, no ready   csr_index, csr_wdata (16 bit)
//
// one request per cycle unless the job queue is full; results go via queue and output register
// parser state moves once per accepted byte, the 4-deep job queue and the output
// register let results wait without stopping the parser until the queue fills
// req_bus.ready drops only while the job queue is full
// synchronous active-high reset: header phase, led_total 1024, max count 5000
module led_frame_deframer_pixel_unpack (
   input  logic                           clock,
   input  logic                           reset,
   lfd_req_if.sink                        req_bus,
   lfd_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [lfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lfd_pkg::*;

   logic    q_full;
   logic    q_push;
   job_type q_job;
   logic    q_pop;
   logic    q_empty;
   job_type q_head;

   lfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_kind      (req_bus.kind),
      .req_data_byte (req_bus.data_byte),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (q_job)
   );

   lfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (q_head)
   );

   lfd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_result_kind (rsp_bus.result_kind),
      .rsp_pixel_index (rsp_bus.pixel_index),
      .rsp_red         (rsp_bus.red),
      .rsp_green       (rsp_bus.green),
      .rsp_blue        (rsp_bus.blue),
      .rsp_white       (rsp_bus.white),
      .rsp_frame_end   (rsp_bus.frame_end),
      .rsp_error_code  (rsp_bus.error_code)
   );

endmodule

FILE: verif/tb_led_frame_deframer_pixel_unpack.sv
`timescale 1ns / 1ps
module tb_led_frame_deframer_pixel_unpack;
   import lfd_pkg::*;

   localparam int CLK_PERIOD = 12;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_LIMIT = 40;
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;
   localparam logic [7:0] LEDS_MAGIC [4] = '{8'h4C, 8'h45, 8'h44, 8'h53};

   typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_DROP} deframe_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] idx;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  white;
      logic        last;
      logic [2:0]  ecode;
   } led_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lfd_req_if req_bus ();
   lfd_rsp_if rsp_bus ();

   led_frame_deframer_pixel_unpack dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted deframer state and registers
   deframe_phase_type ph;
   logic [3:0]  hdr_pos;
   logic [31:0] cnt_acc;
   logic [2:0]  fmt;
   logic [15:0] frame_len;
   logic [15:0] pix_idx;
   logic [1:0]  pix_byte;
   logic [23:0] held;
   logic [15:0] led_total_cfg;
   logic [15:0] max_count_cfg;

   led_result_type pending_results[$];

   int cycle_count = 0;
   int mismatches = 0;
   int requests_sent = 0;
   int headers_sent = 0;
   int pixels_checked = 0;
   int markers_checked = 0;
   int errors_checked = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
                  pending_results.size());
         $display("FAIL led_frame_deframer_pixel_unpack");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch on %s at cycle %0d: got 0x%0h, expected 0x%0h", what,
                  cycle_count, got, want);
      mismatches++;
   endtask

   function automatic void restart_header();
      ph = PH_HEADER;
      hdr_pos = '0;
      cnt_acc = '0;
      pix_byte = '0;
      pix_idx = '0;
   endfunction

   function automatic void expect_result(input led_result_type res);
      pending_results = {pending_results, res};
   endfunction

   task automatic deframe_byte(input logic k, input logic [7:0] b);
      led_result_type res;
      logic bad, four, last;
      logic [2:0] code;
      logic [7:0] c0, c1, c2, r, g, bl;
      logic [15:0] idx;
      res = '0;
      bad = 1'b0;
      code = EC_NONE;
      if (k == KIND_CLOSE) begin
         if (ph == PH_PAYLOAD || (ph == PH_HEADER && hdr_pos != 0)) begin
            bad = 1'b1;
            code = EC_CLOSED;
         end
         restart_header();
      end else if (ph == PH_HEADER) begin
         if (hdr_pos < HDR_POS_VERSION) begin
            bad = (b != LEDS_MAGIC[hdr_pos[1:0]]);
            code = EC_MAGIC;
         end else if (hdr_pos == HDR_POS_VERSION) begin
            bad = (b != HDR_VERSION);
            code = EC_VERSION;
         end else if (hdr_pos <= HDR_POS_COUNT_LAST) begin
            cnt_acc = {cnt_acc[23:0], b};
            if (hdr_pos == HDR_POS_COUNT_LAST) begin
               bad = (cnt_acc == 0) || (cnt_acc > 32'(max_count_cfg));
               code = EC_COUNT;
               if (!bad)
                  frame_len = cnt_acc[15:0];
            end
         end else begin
            bad = (b > 8'(FMT_GRBW));
            code = EC_FORMAT;
         end
         if (bad) begin
            ph = PH_DROP;
         end else if (hdr_pos == HDR_POS_FORMAT) begin
            fmt = b[2:0];
            ph = PH_PAYLOAD;
            pix_idx = '0;
            pix_byte = '0;
            hdr_pos = '0;
         end else begin
            hdr_pos = hdr_pos + 1'b1;
         end
      end else if (ph == PH_PAYLOAD) begin
         four = (fmt == FMT_RGBW) || (fmt == FMT_GRBW);
         if (pix_byte < (four ? 2'd3 : 2'd2)) begin
            held[pix_byte * 8 +: 8] = b;
            pix_byte = pix_byte + 1'b1;
         end else begin
            pix_byte = '0;
            c0 = held[7:0];
            c1 = held[15:8];
            c2 = four ? held[23:16] : b;
            case (fmt)
               FMT_GRB, FMT_GRBW: begin
                  g = c0;
                  r = c1;
                  bl = c2;
               end
               FMT_BGR: begin
                  bl = c0;
                  g = c1;
                  r = c2;
               end
               default: begin
                  r = c0;
                  g = c1;
                  bl = c2;
               end
            endcase
            idx = pix_idx;
            last = (32'(idx) + 1 >= 32'(frame_len));
            pix_idx = idx + 1'b1;
            if (last)
               restart_header();
            if (idx < led_total_cfg) begin
               res.kind = RK_PIXEL;
               res.idx = idx;
               res.red = r;
               res.green = g;
               res.blue = bl;
               res.white = four ? b : 8'((10'(r) + 10'(g) + 10'(bl)) / 10'd3);
               res.last = last;
               expect_result(res);
            end else if (last) begin
               // pixel past the attached strip still closes the frame
               res.kind = RK_MARKER;
               res.idx = idx;
               res.last = 1'b1;
               expect_result(res);
            end
         end
      end
      if (bad) begin
         res.kind = RK_ERROR;
         res.ecode = code;
         expect_result(res);
      end
   endtask

   always @(negedge clock) begin
      led_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none expected", 32'(rsp_bus.result_kind), 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.result_kind !== want.kind)
               report_mismatch("result_kind", 32'(rsp_bus.result_kind), 32'(want.kind));
            if (rsp_bus.pixel_index !== want.idx)
               report_mismatch("pixel_index", 32'(rsp_bus.pixel_index), 32'(want.idx));
            if (rsp_bus.red !== want.red)
               report_mismatch("red", 32'(rsp_bus.red), 32'(want.red));
            if (rsp_bus.green !== want.green)
               report_mismatch("green", 32'(rsp_bus.green), 32'(want.green));
            if (rsp_bus.blue !== want.blue)
               report_mismatch("blue", 32'(rsp_bus.blue), 32'(want.blue));
            if (rsp_bus.white !== want.white)
               report_mismatch("white", 32'(rsp_bus.white), 32'(want.white));
            if (rsp_bus.frame_end !== want.last)
               report_mismatch("frame_end", 32'(rsp_bus.frame_end), 32'(want.last));
            if (rsp_bus.error_code !== want.ecode)
               report_mismatch("error_code", 32'(rsp_bus.error_code), 32'(want.ecode));
            case (want.kind)
               RK_PIXEL: pixels_checked++;
               RK_MARKER: markers_checked++;
               default: errors_checked++;
            endcase
         end
      end
   end

   task automatic send_req(input logic k, input logic [7:0] b);
      bit taken;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= k;
      req_bus.data_byte <= b;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = (req_bus.ready === 1'b1);
         @(posedge clock);
      end
      deframe_byte(k, b);
      requests_sent++;
   endtask

   // drop valid and wait until every result is back and the pipe is empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_LED_TOTAL)
         led_total_cfg = val;
      else
         max_count_cfg = val;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // bad_pos selects one header byte to corrupt, -1 for a clean header
   task automatic send_header(input logic [31:0] cnt, input logic [7:0] fmt_byte,
                              input int bad_pos);
      logic [7:0] hb;
      headers_sent++;
      for (int p = 0; p < 10; p++) begin
         case (p)
            0, 1, 2, 3: hb = LEDS_MAGIC[p];
            int'(HDR_POS_VERSION): hb = HDR_VERSION;
            int'(HDR_POS_FORMAT): hb = fmt_byte;
            default: hb = cnt[(8 - p) * 8 +: 8];
         endcase
         if (p == bad_pos)
            hb = hb ^ 8'($urandom_range(1, 255));
         send_req(KIND_DATA, hb);
      end
   endtask

   task automatic send_payload(input int n_bytes, input int fill);
      for (int i = 0; i < n_bytes; i++)
         send_req(KIND_DATA, (fill < 0) ? rand_byte() : 8'(fill));
   endtask

   task automatic send_frame(input logic [31:0] cnt, input logic [7:0] fmt_byte,
                             input int fill);
      send_header(cnt, fmt_byte, -1);
      send_payload(int'(cnt) * ((fmt_byte >= FMT_RGBW) ? 4 : 3), fill);
   endtask

   // mostly clean frames; the rest are broken headers, cut frames and noise
   task automatic random_frame();
      int sel, cap;
      logic [31:0] cnt, bad_cnt;
      logic [7:0] fmt_byte;
      sel = $urandom_range(99);
      cap = (max_count_cfg < 8) ? int'(max_count_cfg) : 8;
      cnt = $urandom_range(1, cap);
      fmt_byte = 8'($urandom_range(FMT_RGB, FMT_GRBW));
      if (sel < 70) begin
         send_frame(cnt, fmt_byte, -1);
      end else begin
         if (sel < 78) begin
            send_header(cnt, fmt_byte, $urandom_range(0, 9));
            send_payload($urandom_range(0, 3), -1);
         end else if (sel < 85) begin
            send_header(cnt, fmt_byte, -1);
            send_payload($urandom_range(0, int'(cnt) * ((fmt_byte >= FMT_RGBW) ? 4 : 3) - 1),
                         -1);
         end else if (sel < 90) begin
            case ($urandom_range(2))
               0: bad_cnt = 32'd0;
               1: bad_cnt = 32'(max_count_cfg) + $urandom_range(1, 300);
               default: bad_cnt = $urandom | 32'h8000_0000;
            endcase
            send_header(bad_cnt, fmt_byte, -1);
            send_payload($urandom_range(0, 2), -1);
         end else if (sel < 94) begin
            send_header(cnt, 8'($urandom_range(5, 255)), -1);
            send_payload($urandom_range(0, 2), -1);
         end else begin
            repeat ($urandom_range(1, 6)) send_req($urandom_range(3) == 0, rand_byte());
         end
         send_req(KIND_CLOSE, 8'($urandom));
      end
   endtask

   task automatic test_header_errors();
      send_req(KIND_DATA, 8'h4D);
      send_req(KIND_DATA, LEDS_MAGIC[0]);
      send_req(KIND_CLOSE, 8'h00);
      send_header(32'd1, FMT_RGB, int'(HDR_POS_VERSION));
      send_req(KIND_CLOSE, 8'hFF);
      send_header(32'd0, FMT_RGB, -1);
      send_req(KIND_CLOSE, 8'h00);
      // one above the reset limit
      send_header(32'(MAX_COUNT_RST) + 1, FMT_RGB, -1);
      send_req(KIND_CLOSE, 8'hFF);
      send_header(32'hFFFF_FFFF, FMT_GRB, -1);
      send_req(KIND_CLOSE, 8'h00);
      send_header(32'd1, 8'h05, -1);
      send_req(KIND_CLOSE, 8'hFF);
      send_header(32'd1, 8'hFF, -1);
      send_req(KIND_CLOSE, 8'h00);
      settle();
   endtask

   task automatic test_close_events();
      send_req(KIND_CLOSE, 8'h55);
      for (int p = 0; p < 3; p++)
         send_req(KIND_DATA, LEDS_MAGIC[p]);
      send_req(KIND_CLOSE, 8'hAA);
      send_header(32'd2, FMT_RGB, -1);
      send_req(KIND_CLOSE, 8'h00);
      send_header(32'd2, FMT_RGB, -1);
      send_payload(4, -1);
      send_req(KIND_CLOSE, 8'hFF);
      send_req(KIND_CLOSE, 8'h00);
      settle();
   endtask

   task automatic test_formats();
      for (int f = FMT_RGB; f <= FMT_GRBW; f++) begin
         send_frame(32'd1, 8'(f), 8'hFF);
         send_frame(32'd3, 8'(f), -1);
      end
      settle();
   endtask

   task automatic test_led_total_limit();
      write_csr(CSR_LED_TOTAL, 16'd2);
      send_frame(32'd4, FMT_RGB, -1);
      settle();
      write_csr(CSR_LED_TOTAL, 16'd0);
      send_frame(32'd1, FMT_GRBW, -1);
      settle();
      write_csr(CSR_LED_TOTAL, 16'hFFFF);
      write_csr(CSR_MAX_COUNT, 16'd1);
      send_frame(32'd1, FMT_BGR, -1);
      send_header(32'd2, FMT_RGB, -1);
      send_req(KIND_CLOSE, 8'h00);
      settle();
      write_csr(CSR_MAX_COUNT, 16'hFFFF);
      send_header(32'd65535, FMT_RGBW, -1);
      send_payload(8, -1);
      send_req(KIND_CLOSE, 8'hFF);
      settle();
   endtask

   task automatic run_traffic(input int n_req, input int idle_pct, input int stall_pct,
                              input bit hold_off);
      int start;
      bit paused;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = requests_sent;
      paused = 1'b0;
      while (requests_sent - start < n_req) begin
         random_frame();
         if (hold_off && !paused && requests_sent - start >= n_req / 2) begin
            settle();
            paused = 1'b1;
         end
      end
      settle();
   endtask

   task automatic test_random_traffic();
      write_csr(CSR_LED_TOTAL, 16'd5);
      write_csr(CSR_MAX_COUNT, 16'd8);
      run_traffic(50, 0, 0, 1'b0);
      write_csr(CSR_LED_TOTAL, 16'hFFFF);
      write_csr(CSR_MAX_COUNT, 16'hFFFF);
      run_traffic(50, 61, 0, 1'b1);
      write_csr(CSR_LED_TOTAL, 16'd0);
      write_csr(CSR_MAX_COUNT, 16'd1);
      run_traffic(50, 0, 61, 1'b0);
      write_csr(CSR_LED_TOTAL, 16'($urandom_range(0, 10)));
      write_csr(CSR_MAX_COUNT, 16'($urandom_range(1, 12)));
      run_traffic(50, 6, 6, 1'b0);
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.kind <= KIND_DATA;
      req_bus.data_byte <= 8'h00;
      csr_we <= 1'b0;
      csr_index <= CSR_LED_TOTAL;
      csr_wdata <= '0;
      reset <= 1'b1;
      restart_header();
      fmt = FMT_RGB;
      frame_len = '0;
      held = '0;
      led_total_cfg = LED_TOTAL_RST;
      max_count_cfg = MAX_COUNT_RST;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_header_errors();
      test_close_events();
      test_formats();
      test_led_total_limit();
      test_random_traffic();

      $display("sent %0d requests over %0d frame headers, four idle/stall mixes",
               requests_sent, headers_sent);
      $display("checked %0d pixels, %0d frame-end markers, %0d error results",
               pixels_checked, markers_checked, errors_checked);
      if (mismatches == 0) begin
         $display("PASS led_frame_deframer_pixel_unpack");
      end else begin
         $display("FAIL led_frame_deframer_pixel_unpack");
      end
      $finish;
   end

endmodule
